@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the UTF-8 sample validator.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/utf8v_pkg.sv @@
// ---------------------------------------------------------------------------
// utf8v_pkg
// Types, byte-class constants and lead decode for the UTF-8 sample validator.
// ---------------------------------------------------------------------------
package utf8v_pkg;

	localparam logic [7:0] ASCII_TOP = 8'h80;
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_TAG  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_TAG  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_TAG  = 8'hF0;
	localparam logic [7:0] LEAD_MIN   = 8'hC2;
	localparam logic [7:0] LEAD_MAX   = 8'hF4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} beat_t;

	typedef struct packed {
		logic  valid;
		beat_t beat;
	} stage_t;

	typedef struct packed {
		logic still_valid;
		logic char_complete;
		logic sample_done;
		logic final_verdict;
	} result_t;

	function automatic logic [1:0] lead_length(input logic [7:0] b);
		logic [1:0] len;
		begin
			len = 2'd0;
			if (b >= LEAD_MIN && b <= LEAD_MAX) begin
				if ((b & LEAD2_MASK) == LEAD2_TAG)
					len = 2'd1;
				else if ((b & LEAD3_MASK) == LEAD3_TAG)
					len = 2'd2;
				else if ((b & LEAD4_MASK) == LEAD4_TAG)
					len = 2'd3;
			end
			return len;
		end
	endfunction

endpackage

@@ rtl/utf8v_in_stage.sv @@
// ---------------------------------------------------------------------------
// utf8v_in_stage
// Input register: captures one beat per cycle while in_stall is low and holds it until taken.
// ---------------------------------------------------------------------------
module utf8v_in_stage
	import utf8v_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       take,
	output stage_t     stage_s1
);

	logic  valid_s1;
	beat_t beat_s1;

	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			beat_s1.data_byte <= data_byte;
			beat_s1.last_byte <= last_byte;
		end
	end

	assign stage_s1.valid = valid_s1;
	assign stage_s1.beat  = beat_s1;

endmodule

@@ rtl/utf8v_check.sv @@
// ---------------------------------------------------------------------------
// utf8v_check
// Sequence state, per-byte check and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8v_check
	import utf8v_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  stage_t  stage_s1,
	output logic    take,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t res_s2
);

	logic [1:0] pend_q;
	logic       tent_q;
	logic       conf_q;
	logic       valid_s2;
	logic       can_load;

	logic [1:0] pend_n;
	logic       tent_n;
	logic       conf_n;
	logic       complete;
	logic [1:0] len;
	logic [7:0] b;
	result_t    res_n;

	assign can_load  = !valid_s2 || !out_stall;
	assign take      = stage_s1.valid && can_load;
	assign out_valid = valid_s2;
	assign b         = stage_s1.beat.data_byte;
	assign len       = lead_length(b);

	always_comb begin
		pend_n   = pend_q;
		tent_n   = tent_q;
		conf_n   = conf_q;
		complete = 1'b0;
		if (pend_q != 2'd0) begin
			if ((b & CONT_MASK) != CONT_TAG)
				tent_n = 1'b1;
			pend_n = pend_q - 2'd1;
			if (pend_n == 2'd0) begin
				if (tent_n)
					conf_n = 1'b1;
				else
					complete = 1'b1;
				tent_n = 1'b0;
			end
		end else if (b < ASCII_TOP) begin
			complete = 1'b1;
		end else begin
			if (len == 2'd0)
				conf_n = 1'b1;
			else
				pend_n = len;
			tent_n = 1'b0;
		end

		res_n.still_valid   = !conf_n;
		res_n.char_complete = complete;
		res_n.sample_done   = stage_s1.beat.last_byte;
		res_n.final_verdict = stage_s1.beat.last_byte && !conf_n;

		// clear for the next sample
		if (stage_s1.beat.last_byte) begin
			pend_n = 2'd0;
			tent_n = 1'b0;
			conf_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 2'd0;
			tent_q   <= 1'b0;
			conf_q   <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				pend_q <= pend_n;
				tent_q <= tent_n;
				conf_q <= conf_n;
			end
			if (can_load)
				valid_s2 <= stage_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			res_s2 <= res_n;
	end

	`ASSERT_IMPLY(a_tent_in_seq, clk, arst_n, tent_q, pend_q != 2'd0)
	`ASSERT_NEXT(a_last_clears, clk, arst_n, take && stage_s1.beat.last_byte,
		pend_q == 2'd0 && !tent_q && !conf_q)
	`ASSERT_IMPLY(a_verdict_done, clk, arst_n, valid_s2 && res_s2.final_verdict,
		res_s2.sample_done)
	`ASSERT_IMPLY(a_verdict_match, clk, arst_n, valid_s2 && res_s2.sample_done,
		res_s2.final_verdict == res_s2.still_valid)

endmodule

@@ rtl/utf8_sample_validator_top.sv @@
// ---------------------------------------------------------------------------
// utf8_sample_validator_top
// UTF-8 validity check over byte samples, one byte per beat.
// ---------------------------------------------------------------------------
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// input    | in_valid / in_stall  | data_byte, last_byte
// output   | out_valid / out_stall| still_valid, char_complete, sample_done,
//          |                      | final_verdict
//
// One beat per cycle sustained while out_stall is low; a beat passes through the
// input register, then the result register, before its result is presented.
// Reset clears the sequence state and both valid flags; no sample is open.
// A stalled result holds the result register; the input register still takes
// a beat if it is empty, then in_stall rises until the result moves.
// ---------------------------------------------------------------------------
module utf8_sample_validator_top
	import utf8v_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       still_valid,
	output logic       char_complete,
	output logic       sample_done,
	output logic       final_verdict
);

	stage_t  stage_s1;
	result_t res_s2;
	logic    take;

	utf8v_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.take      (take),
		.stage_s1  (stage_s1)
	);

	utf8v_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage_s1  (stage_s1),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_s2    (res_s2)
	);

	assign still_valid   = res_s2.still_valid;
	assign char_complete = res_s2.char_complete;
	assign sample_done   = res_s2.sample_done;
	assign final_verdict = res_s2.final_verdict;

endmodule
